[design/detector_cell_decode_top_macros.svh]
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef DETECTOR_CELL_DECODE_TOP_MACROS_SVH
`define DETECTOR_CELL_DECODE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/dcd_pkg.sv]
package dcd_pkg;

  localparam int DEF_MAX_CLASSES = 80;

  localparam int VAL_W = 16;
  localparam int PIX_W = 13;
  localparam int EDGE_W = 14;
  localparam int CLS_W = 8;
  localparam int POS_W = 9;

  // Configuration register indexes
  localparam logic [1:0] CFG_CONF_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_NUM_CLASSES = 2'd3;

  // Configuration reset values
  localparam logic [15:0] RST_CONF_THRESHOLD = 16'd11469;
  localparam logic [12:0] RST_IMAGE_WIDTH = 13'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd640;
  localparam logic [7:0] RST_NUM_CLASSES = 8'd80;

  // Fixed positions inside a cell
  localparam logic [8:0] POS_OBJ = 9'd4;
  localparam logic [8:0] POS_FIRST_CLASS = 9'd5;

  // One finished cell, handed from the accumulator to the decode stage
  typedef struct packed {
    logic [3:0][VAL_W-1:0] box;
    logic [VAL_W-1:0] obj;
    logic [VAL_W-1:0] best_score;
    logic [CLS_W-1:0] best_class;
  } cell_t;

endpackage

[design/dcd_accum.sv]
`include "detector_cell_decode_top_macros.svh"

module dcd_accum #(
  parameter int MAX_CLASSES = dcd_pkg::DEF_MAX_CLASSES
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [dcd_pkg::VAL_W-1:0] value,
  input  logic [7:0] num_classes,
  input  logic cell_take,
  output logic cell_valid,
  output dcd_pkg::cell_t cell_data
);

  localparam logic [8:0] MAX_C9 = 9'(MAX_CLASSES);

  logic [dcd_pkg::POS_W-1:0] position;
  logic [3:0][dcd_pkg::VAL_W-1:0] box;
  logic [dcd_pkg::VAL_W-1:0] obj;
  logic [dcd_pkg::VAL_W-1:0] best_score;
  logic [dcd_pkg::CLS_W-1:0] best_class;

  logic in_accept;
  logic [8:0] n_eff;
  logic last_beat;
  logic take_new;
  logic [dcd_pkg::VAL_W-1:0] best_score_next;
  logic [dcd_pkg::CLS_W-1:0] best_class_next;
  logic [dcd_pkg::CLS_W-1:0] cls;

  // Hold input while a finished cell cannot leave
  assign in_stall = cell_valid & ~cell_take;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    if (num_classes == 8'd0) begin
      n_eff = 9'd1;
    end else if ({1'b0, num_classes} > MAX_C9) begin
      n_eff = MAX_C9;
    end else begin
      n_eff = {1'b0, num_classes};
    end
  end

  assign cls = 8'(position - dcd_pkg::POS_FIRST_CLASS);
  assign take_new = (position == dcd_pkg::POS_FIRST_CLASS) || (value > best_score);
  assign best_score_next = take_new ? value : best_score;
  assign best_class_next = take_new ? cls : best_class;
  assign last_beat = (position >= dcd_pkg::POS_FIRST_CLASS) &&
                     (position >= dcd_pkg::POS_OBJ + n_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (in_accept) begin
      if (last_beat) begin
        position <= '0;
      end else begin
        position <= position + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (position < dcd_pkg::POS_OBJ) begin
        box[position[1:0]] <= value;
      end else if (position == dcd_pkg::POS_OBJ) begin
        obj <= value;
      end else begin
        best_score <= best_score_next;
        best_class <= best_class_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (in_accept && last_beat) begin
      cell_valid <= 1'b1;
    end else if (cell_take) begin
      cell_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_beat) begin
      cell_data.box <= box;
      cell_data.obj <= obj;
      cell_data.best_score <= best_score_next;
      cell_data.best_class <= best_class_next;
    end
  end

  `DCD_ASSERT_NEXT(a_cell_close, in_accept && last_beat, cell_valid && position == '0, "open cell")
  `DCD_ASSERT_NOW(a_cell_source, $rose(cell_valid), $past(in_accept), "orphan cell")
  `DCD_ASSERT_NOW(a_pos_bound, in_valid, position <= dcd_pkg::POS_OBJ + MAX_C9, "position overrun")

endmodule

[design/dcd_compute.sv]
`include "detector_cell_decode_top_macros.svh"

module dcd_compute (
  input  logic clk,
  input  logic rst,
  input  logic cell_valid,
  input  dcd_pkg::cell_t cell_data,
  output logic cell_take,
  input  logic [15:0] conf_threshold,
  input  logic [12:0] image_width,
  input  logic [12:0] image_height,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] class_idx,
  output logic [15:0] score,
  output logic [12:0] center_x,
  output logic [12:0] center_y,
  output logic [12:0] box_width,
  output logic [12:0] box_height,
  output logic signed [13:0] left,
  output logic signed [13:0] top
);

  function automatic logic [12:0] scale_pix(input logic [15:0] v, input logic [12:0] s);
    logic [28:0] p;
    p = v * s;
    return (p[28:15] > 14'd8191) ? 13'd8191 : p[27:15];
  endfunction

  function automatic logic [13:0] edge_pix(input logic [15:0] c, input logic [15:0] s,
                                           input logic [12:0] sc);
    logic signed [18:0] d;
    logic signed [32:0] num;
    logic signed [32:0] adj;
    logic signed [16:0] q;
    d = $signed({2'b00, c, 1'b0}) - $signed({3'b000, s});
    num = d * $signed({1'b0, sc});
    adj = (num < 0) ? num + 33'sd65535 : num;
    q = 17'(adj >>> 16);
    if (q > 17'sd8191) begin
      return 14'h1FFF;
    end else if (q < -17'sd8192) begin
      return 14'h2000;
    end else begin
      return q[13:0];
    end
  endfunction

  logic [31:0] prod;
  logic [15:0] score_c;
  logic pass;

  assign prod = cell_data.obj * cell_data.best_score;
  assign score_c = prod[31] ? 16'hFFFF : prod[30:15];
  assign pass = (cell_data.obj >= conf_threshold) && (score_c >= conf_threshold);

  // Advance when the result register is empty or being drained
  assign cell_take = cell_valid & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cell_take) begin
      out_valid <= pass;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_take && pass) begin
      class_idx <= cell_data.best_class;
      score <= score_c;
      center_x <= scale_pix(cell_data.box[0], image_width);
      center_y <= scale_pix(cell_data.box[1], image_height);
      box_width <= scale_pix(cell_data.box[2], image_width);
      box_height <= scale_pix(cell_data.box[3], image_height);
      left <= $signed(edge_pix(cell_data.box[0], cell_data.box[2], image_width));
      top <= $signed(edge_pix(cell_data.box[1], cell_data.box[3], image_height));
    end
  end

  `DCD_ASSERT_NOW(a_out_source, $rose(out_valid), $past(cell_valid), "orphan result")
  `DCD_ASSERT_NEXT(a_no_pass_no_out, cell_take && !pass, !out_valid, "failed cell produced a result")

endmodule

[design/detector_cell_decode_top.sv]
// Detector cell decoder.
// Input (in_valid / in_stall / value): one Q1.15 beat per cycle unless stalled,
// each cell in order: x, y, w, h, objectness, then num_classes class scores.
// Output channel (out_valid / out_stall / class_idx ... top): one detection beat
// for each cell that passes the confidence threshold; failing cells emit nothing.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 threshold, 1 image width, 2 image height, 3 class count).
// Throughput: one input beat per cycle, sustained. The input stalls only when a
// decoded cell waits in the decode stage while the result register is held.
// Pipeline: two register stages. The edge that accepts the last class beat
// loads the cell register; the cell moves on into the result register when
// that is empty or being drained, and the detection is offered from there.
// The running argmax is one compare per beat; the decode stage holds the score
// product and the six pixel products side by side between two registers.
// Reset (rst, synchronous): restores the register defaults, restarts the cell
// at its first box value and drops any pending detection.
// Receiver stall: the result register holds its beat; one more finished cell
// can wait behind it before the input is stalled.
module detector_cell_decode_top #(
  parameter int MAX_CLASSES = dcd_pkg::DEF_MAX_CLASSES
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [15:0] value,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] class_idx,
  output logic [15:0] score,
  output logic [12:0] center_x,
  output logic [12:0] center_y,
  output logic [12:0] box_width,
  output logic [12:0] box_height,
  output logic signed [13:0] left,
  output logic signed [13:0] top
);

  logic [15:0] conf_threshold;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [7:0] num_classes;

  // Handshake between accumulator and decode stage
  logic cell_valid;
  logic cell_take;
  dcd_pkg::cell_t cell_data;

  // Register file: decode the index, keep only the register's own width
  always_ff @(posedge clk) begin
    if (rst) begin
      conf_threshold <= dcd_pkg::RST_CONF_THRESHOLD;
      image_width <= dcd_pkg::RST_IMAGE_WIDTH;
      image_height <= dcd_pkg::RST_IMAGE_HEIGHT;
      num_classes <= dcd_pkg::RST_NUM_CLASSES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcd_pkg::CFG_CONF_THRESHOLD: conf_threshold <= cfg_data;
        dcd_pkg::CFG_IMAGE_WIDTH: image_width <= cfg_data[12:0];
        dcd_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        dcd_pkg::CFG_NUM_CLASSES: num_classes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Collect box, objectness and the running argmax; close the cell on the
  // last class beat
  dcd_accum #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .num_classes(num_classes),
    .cell_take(cell_take),
    .cell_valid(cell_valid),
    .cell_data(cell_data)
  );

  // Score, threshold test and pixel scaling into the result register
  dcd_compute u_compute (
    .clk(clk),
    .rst(rst),
    .cell_valid(cell_valid),
    .cell_data(cell_data),
    .cell_take(cell_take),
    .conf_threshold(conf_threshold),
    .image_width(image_width),
    .image_height(image_height),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .class_idx(class_idx),
    .score(score),
    .center_x(center_x),
    .center_y(center_y),
    .box_width(box_width),
    .box_height(box_height),
    .left(left),
    .top(top)
  );

endmodule

[dv/tb_detector_cell_decode_top.sv]
module tb_detector_cell_decode_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CLS = dcd_pkg::DEF_MAX_CLASSES;
  // Receiver hold-off used to back the block up into its input.
  localparam int HOLD_OFF = 200;
  // Generous ceiling on the whole run, in clock cycles.
  localparam int LIMIT = 200000;
  // Input beats offered per random phase.
  localparam int PHASE_BEATS = 70;
  localparam int NUM_PHASES = 9;

  // One detection as it leaves the block, fields in port order.
  typedef struct packed {
    logic [dcd_pkg::CLS_W-1:0] cls;
    logic [dcd_pkg::VAL_W-1:0] score;
    logic [dcd_pkg::PIX_W-1:0] cx;
    logic [dcd_pkg::PIX_W-1:0] cy;
    logic [dcd_pkg::PIX_W-1:0] bw;
    logic [dcd_pkg::PIX_W-1:0] bh;
    logic signed [dcd_pkg::EDGE_W-1:0] lft;
    logic signed [dcd_pkg::EDGE_W-1:0] tp;
  } detection_t;

  // Cell decoder: tracks the cell being streamed in, and queues the
  // detection each passing cell must produce.
  class cell_decoder;
    logic [15:0] thr;
    logic [12:0] img_w;
    logic [12:0] img_h;
    logic [7:0] n_cls;
    int unsigned pos;
    logic [15:0] box [4];
    logic [15:0] obj;
    logic [15:0] best;
    logic [7:0] best_cls;
    detection_t due_detections[$];
    int errors;

    function new();
      thr = dcd_pkg::RST_CONF_THRESHOLD;
      img_w = dcd_pkg::RST_IMAGE_WIDTH;
      img_h = dcd_pkg::RST_IMAGE_HEIGHT;
      n_cls = dcd_pkg::RST_NUM_CLASSES;
      pos = 0;
      foreach (box[i]) box[i] = '0;
      obj = '0;
      best = '0;
      best_cls = '0;
      errors = 0;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        dcd_pkg::CFG_CONF_THRESHOLD: thr = data;
        dcd_pkg::CFG_IMAGE_WIDTH: img_w = data[12:0];
        dcd_pkg::CFG_IMAGE_HEIGHT: img_h = data[12:0];
        dcd_pkg::CFG_NUM_CLASSES: n_cls = data[7:0];
        default: ;
      endcase
    endfunction

    // Beats in one cell under the current class count (zero acts as one,
    // the count is capped at the class limit).
    function int cell_length();
      int n;
      n = n_cls;
      if (n == 0) n = 1;
      if (n > MAX_CLS) n = MAX_CLS;
      return 5 + n;
    endfunction

    function int pending();
      return due_detections.size();
    endfunction

    function logic [12:0] pixel(logic [15:0] v, logic [12:0] s);
      logic [31:0] p;
      p = (32'(v) * 32'(s)) >> 15;
      return (p > 32'd8191) ? 13'd8191 : p[12:0];
    endfunction

    // Corner = (2c - s) * scale / 65536, truncated toward zero, clamped.
    function logic [13:0] corner(logic [15:0] c, logic [15:0] s, logic [12:0] sc);
      longint num;
      longint q;
      num = (2 * longint'(c) - longint'(s)) * longint'(sc);
      q = num / 65536;
      if (q > 8191) q = 8191;
      if (q < -8192) q = -8192;
      return q[13:0];
    endfunction

    function void take_value(logic [15:0] v);
      int unsigned last;
      logic [63:0] prod;
      logic [15:0] sc;
      detection_t d;
      last = cell_length() - 1;
      if (pos < 4) begin
        box[pos] = v;
        pos++;
        return;
      end
      if (pos == 4) begin
        obj = v;
        pos++;
        return;
      end
      // Strictly greater replaces the best, so the first of equal scores stays.
      if (pos == 5 || v > best) begin
        best = v;
        best_cls = 8'(pos - 5);
      end
      if (pos < last) begin
        pos++;
        return;
      end
      pos = 0;
      prod = (64'(obj) * 64'(best)) >> 15;
      sc = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
      if (obj < thr || sc < thr) return;
      d.cls = best_cls;
      d.score = sc;
      d.cx = pixel(box[0], img_w);
      d.cy = pixel(box[1], img_h);
      d.bw = pixel(box[2], img_w);
      d.bh = pixel(box[3], img_h);
      d.lft = corner(box[0], box[2], img_w);
      d.tp = corner(box[1], box[3], img_h);
      due_detections = {due_detections, d};
    endfunction

    function string fmt(detection_t d);
      return $sformatf("cls %0d score %0d cx %0d cy %0d w %0d h %0d left %0d top %0d",
                       d.cls, d.score, d.cx, d.cy, d.bw, d.bh,
                       $signed(d.lft), $signed(d.tp));
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void match_detection(detection_t act);
      detection_t want;
      if (due_detections.size() == 0) begin
        flag({"unexpected detection: ", fmt(act)});
        return;
      end
      want = due_detections.pop_front();
      if (act.cls !== want.cls || act.score !== want.score ||
          act.cx !== want.cx || act.cy !== want.cy ||
          act.bw !== want.bw || act.bh !== want.bh ||
          act.lft !== want.lft || act.tp !== want.tp) begin
        flag({"detection mismatch\n  expected ", fmt(want), "\n  actual   ", fmt(act)});
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = dcd_pkg::CFG_CONF_THRESHOLD;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] class_idx;
  logic [15:0] score;
  logic [12:0] center_x;
  logic [12:0] center_y;
  logic [12:0] box_width;
  logic [12:0] box_height;
  logic signed [13:0] left;
  logic signed [13:0] top;

  cell_decoder sb;
  int cycles = 0;
  int beats_sent = 0;
  // Idle-free stretches for sender and receiver.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  // Main flow asks the receiver for one long hold-off.
  bit hold_req = 1'b0;

  detector_cell_decode_top #(.MAX_CLASSES(MAX_CLS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .class_idx(class_idx),
    .score(score),
    .center_x(center_x),
    .center_y(center_y),
    .box_width(box_width),
    .box_height(box_height),
    .left(left),
    .top(top)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_detector_cell_decode_top: errors");
      $finish;
    end
  end

  // Feed every accepted input beat to the decoder copy.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.take_value(value);
  end

  // Check every accepted output beat against the oldest pending detection.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.match_detection({class_idx, score, center_x, center_y,
                          box_width, box_height, left, top});
    end
  end

  // Receiver: random stall runs, mostly short, a few long; open runs between.
  // On request, hold off for a fixed stretch so the block backs up.
  initial begin
    int run;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_OFF) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else if (rx_quiet || $urandom_range(0, 99) >= 35) begin
        run = $urandom_range(1, 8);
        repeat (run) begin
          @(negedge clk);
          out_stall <= 1'b0;
        end
      end else begin
        run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (run) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly uniform, with a fair share of the corner values.
  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one beat after a random gap; hold it until accepted.
  task automatic send_value(input logic [15:0] v);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_values(input logic [15:0] vs[$]);
    foreach (vs[i]) send_value(vs[i]);
  endtask

  // Random cell: box and objectness, then class scores, sometimes drawn
  // from a narrow band so equal maxima show up.
  task automatic send_random_cell();
    int len;
    bit ties;
    logic [15:0] lvl;
    len = sb.cell_length();
    ties = ($urandom_range(0, 3) == 0);
    lvl = rand_value();
    for (int i = 0; i < len; i++) begin
      if (i < 4) begin
        send_value(rand_value());
      end else if (i == 4) begin
        send_value(($urandom_range(0, 9) < 7) ? 16'($urandom_range(9000, 65535))
                                              : rand_value());
      end else if (ties) begin
        send_value($urandom_range(0, 1) ? lvl : 16'($urandom_range(0, lvl)));
      end else begin
        send_value(rand_value());
      end
    end
  endtask

  // Drop valid, wait for every pending detection, then let the pipe go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] thr, input logic [12:0] w,
                           input logic [12:0] h, input logic [7:0] n);
    cfg_write(dcd_pkg::CFG_CONF_THRESHOLD, thr);
    cfg_write(dcd_pkg::CFG_IMAGE_WIDTH, 16'(w));
    cfg_write(dcd_pkg::CFG_IMAGE_HEIGHT, 16'(h));
    cfg_write(dcd_pkg::CFG_NUM_CLASSES, 16'(n));
  endtask

  function automatic logic [12:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd8191;
      3: return 13'd4096;
      4: return 13'd640;
      default: return 13'($urandom_range(1, 8191));
    endcase
  endfunction

  function automatic logic [15:0] rand_thr();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return dcd_pkg::RST_CONF_THRESHOLD;
      3, 4, 5, 6: return 16'($urandom_range(0, 20000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Class count: mostly small so cells stay short; a few at and past the cap.
  function automatic logic [7:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(1, 6));
    if (r < 60) return 8'd0;
    if (r < 68) return 8'(MAX_CLS);
    if (r < 76) return 8'd255;
    return 8'($urandom_range(7, 30));
  endfunction

  initial begin
    logic [15:0] vals[$];
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero class count acts as one; zero image height zeroes the y axis;
    // full-scale box saturates x and width.
    configure(16'd0, 13'd8191, 13'd0, 8'd0);
    vals = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF};
    send_values(vals);
    settle();

    // Highest threshold, tie on the top score (first class wins), score
    // saturates; left is 1 with x full, width zero, image width 1; top negative.
    configure(16'hFFFF, 13'd1, 13'd4096, 8'd2);
    vals = {16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_values(vals);
    settle();

    // Class count past the cap, then cut short mid cell: the position is
    // already past the new last class, so the next beat ends the cell.
    configure(dcd_pkg::RST_CONF_THRESHOLD, 13'd640, 13'd640, 8'd255);
    vals = {16'd20000, 16'd30000, 16'd9000, 16'd12000, 16'hFFFF,
            16'd1000, 16'd30000, 16'd3000};
    send_values(vals);
    settle();
    cfg_write(dcd_pkg::CFG_NUM_CLASSES, 16'd1);
    send_value(16'd2000);
    settle();

    // Objectness under threshold while the score alone would pass.
    vals = {16'd100, 16'd200, 16'd300, 16'd400, 16'd10000, 16'hFFFF};
    send_values(vals);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      int stop;
      tx_quiet = (p % 4 == 1);
      rx_quiet = (p % 4 == 1);
      if (p == 3) begin
        // Back-pressure phase: every cell passes, cells are short, the sender
        // streams without gaps while the receiver holds off for a long stretch.
        configure(16'd0, rand_size(), rand_size(), 8'd0);
        tx_quiet = 1'b1;
        hold_req = 1'b1;
      end else begin
        configure(rand_thr(), rand_size(), rand_size(), rand_count());
      end
      stop = beats_sent + PHASE_BEATS;
      while (beats_sent < stop) send_random_cell();
      settle();
    end

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_detector_cell_decode_top: clean");
    end else begin
      $display("tb_detector_cell_decode_top: errors");
    end
    $finish;
  end

endmodule
